/* rtl/ltdc_pkg.sv */
package ltdc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS   = 3'd4;

  localparam logic [15:0] SETTLE_TICKS_RESET = 16'd30;
  localparam logic [11:0] PROBE_OFFSET_RESET = 12'd20;
  localparam logic [11:0] DEADBAND_RESET     = 12'd15;
  localparam logic [11:0] STEP_SIZE_RESET    = 12'd10;
  localparam logic [15:0] HOLD_TICKS_RESET   = 16'd10;
  localparam logic [15:0] CENTER_RESET       = 16'd1500;

  typedef enum logic [2:0] {
    PH_LEFT  = 3'd0,
    PH_RIGHT = 3'd1,
    PH_UP    = 3'd2,
    PH_DOWN  = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [11:0] probe_offset;
    logic [11:0] deadband;
    logic [11:0] step_size;
    logic [15:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tick_count;
    logic [11:0] reading_left;
    logic [11:0] reading_right;
    logic [11:0] reading_up;
    logic [15:0] center_pan;
    logic [15:0] center_tilt;
    logic [15:0] pan_level;
    logic [15:0] tilt_level;
  } state_t;

  typedef struct packed {
    logic [15:0] pan_drive;
    logic [15:0] tilt_drive;
    logic [15:0] center_pan;
    logic [15:0] center_tilt;
    logic [2:0]  probe_phase;
    logic        cycle_done;
  } result_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [11:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {5'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [11:0] b);
    logic [15:0] bw;
    bw = {4'b0, b};
    return (a > bw) ? (a - bw) : 16'd0;
  endfunction

endpackage

/* rtl/ltdc_step.sv */
module ltdc_step (
  input  ltdc_pkg::cfg_t    cfg,
  input  ltdc_pkg::state_t  cur,
  input  logic [11:0]       light_sample,
  output ltdc_pkg::state_t  nxt,
  output ltdc_pkg::result_t res
);

  ltdc_pkg::phase_t ph;
  logic [15:0]      tc;
  logic [15:0]      tc1;
  logic             latch;
  logic             done;
  logic [12:0]      left_lim;
  logic [12:0]      right_lim;
  logic [12:0]      up_lim;
  logic [12:0]      down_lim;
  logic [15:0]      pan_new;
  logic [15:0]      tilt_new;

  // Center correction: the down sample is the one arriving on this tick.
  always_comb begin
    left_lim  = {1'b0, cur.reading_right} + {1'b0, cfg.deadband};
    right_lim = {1'b0, cur.reading_left} + {1'b0, cfg.deadband};
    up_lim    = {1'b0, light_sample} + {1'b0, cfg.deadband};
    down_lim  = {1'b0, cur.reading_up} + {1'b0, cfg.deadband};

    pan_new = cur.center_pan;
    if ({1'b0, cur.reading_left} > left_lim) begin
      pan_new = ltdc_pkg::sat_sub16(cur.center_pan, cfg.step_size);
    end else if ({1'b0, cur.reading_right} > right_lim) begin
      pan_new = ltdc_pkg::sat_add16(cur.center_pan, cfg.step_size);
    end

    tilt_new = cur.center_tilt;
    if ({1'b0, cur.reading_up} > up_lim) begin
      tilt_new = ltdc_pkg::sat_add16(cur.center_tilt, cfg.step_size);
    end else if ({1'b0, light_sample} > down_lim) begin
      tilt_new = ltdc_pkg::sat_sub16(cur.center_tilt, cfg.step_size);
    end
  end

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    case (cur.phase)
      ltdc_pkg::PH_LEFT, ltdc_pkg::PH_RIGHT, ltdc_pkg::PH_UP,
      ltdc_pkg::PH_DOWN, ltdc_pkg::PH_HOLD: begin
        ph = cur.phase;
        tc = cur.tick_count;
      end
      default: begin
        ph = ltdc_pkg::PH_LEFT;
        tc = 16'd0;
      end
    endcase
    nxt.phase = ph;
    tc1       = tc + 16'd1;
    latch     = (tc1 >= cfg.settle_ticks) || (tc1 == 16'd0);
    nxt.tick_count = tc1;

    case (ph)
      ltdc_pkg::PH_HOLD: begin
        nxt.pan_level  = cur.center_pan;
        nxt.tilt_level = cur.center_tilt;
        if (tc1 >= cfg.hold_ticks) begin
          nxt.phase      = ltdc_pkg::PH_LEFT;
          nxt.tick_count = 16'd0;
        end
      end
      ltdc_pkg::PH_RIGHT: begin
        nxt.pan_level = ltdc_pkg::sat_add16(cur.center_pan, cfg.probe_offset);
        if (latch) begin
          nxt.tick_count    = 16'd0;
          nxt.reading_right = light_sample;
          nxt.phase         = ltdc_pkg::PH_UP;
        end
      end
      ltdc_pkg::PH_UP: begin
        nxt.tilt_level = ltdc_pkg::sat_add16(cur.center_tilt, cfg.probe_offset);
        if (latch) begin
          nxt.tick_count = 16'd0;
          nxt.reading_up = light_sample;
          nxt.phase      = ltdc_pkg::PH_DOWN;
        end
      end
      ltdc_pkg::PH_DOWN: begin
        nxt.tilt_level = ltdc_pkg::sat_sub16(cur.center_tilt, cfg.probe_offset);
        if (latch) begin
          nxt.tick_count  = 16'd0;
          nxt.center_pan  = pan_new;
          nxt.center_tilt = tilt_new;
          nxt.pan_level   = pan_new;
          nxt.tilt_level  = tilt_new;
          done            = 1'b1;
          nxt.phase       = (cfg.hold_ticks == 16'd0) ? ltdc_pkg::PH_LEFT : ltdc_pkg::PH_HOLD;
        end
      end
      default: begin
        nxt.pan_level = ltdc_pkg::sat_sub16(cur.center_pan, cfg.probe_offset);
        if (latch) begin
          nxt.tick_count   = 16'd0;
          nxt.reading_left = light_sample;
          nxt.phase        = ltdc_pkg::PH_RIGHT;
        end
      end
    endcase

    res.pan_drive   = nxt.pan_level;
    res.tilt_drive  = nxt.tilt_level;
    res.center_pan  = nxt.center_pan;
    res.center_tilt = nxt.center_tilt;
    res.probe_phase = nxt.phase;
    res.cycle_done  = done;
  end

endmodule

/* rtl/light_tracker_dither_control.sv */
// Dithering light tracker. Each accepted item is one millisecond tick with a
// light sample; every tick yields exactly one result item with the servo
// drives, the tracked centers, the probe phase and a flag on the correction
// tick. One item is taken per clock unless stalled; a tick's state update is
// one pass of 16-bit add/compare logic into the state registers; results go
// to an output register backed by a one-entry skid register, so sample_stall
// rises only when both are full. Configuration registers are written through
// cfg_write/cfg_index/cfg_data; user rule, not enforced: no item in flight.
module light_tracker_dither_control (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ltdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ltdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [11:0]                      light_sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [15:0]                      pan_drive,
  output logic [15:0]                      tilt_drive,
  output logic [15:0]                      center_pan_out,
  output logic [15:0]                      center_tilt_out,
  output logic [2:0]                       probe_phase,
  output logic                             cycle_done
);

  ltdc_pkg::cfg_t    cfg;
  ltdc_pkg::state_t  state;
  ltdc_pkg::state_t  state_next;
  ltdc_pkg::result_t res_next;
  ltdc_pkg::result_t out_reg;
  ltdc_pkg::result_t skid_reg;
  logic              skid_valid;
  logic              accept;
  logic              take;

  assign sample_stall = skid_valid;
  assign accept       = sample_valid && !sample_stall;
  assign take         = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks <= ltdc_pkg::SETTLE_TICKS_RESET;
      cfg.probe_offset <= ltdc_pkg::PROBE_OFFSET_RESET;
      cfg.deadband     <= ltdc_pkg::DEADBAND_RESET;
      cfg.step_size    <= ltdc_pkg::STEP_SIZE_RESET;
      cfg.hold_ticks   <= ltdc_pkg::HOLD_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ltdc_pkg::CFG_SETTLE_TICKS: cfg.settle_ticks <= cfg_data;
        ltdc_pkg::CFG_PROBE_OFFSET: cfg.probe_offset <= cfg_data[11:0];
        ltdc_pkg::CFG_DEADBAND:     cfg.deadband     <= cfg_data[11:0];
        ltdc_pkg::CFG_STEP_SIZE:    cfg.step_size    <= cfg_data[11:0];
        ltdc_pkg::CFG_HOLD_TICKS:   cfg.hold_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  ltdc_step u_step (
    .cfg          (cfg),
    .cur          (state),
    .light_sample (light_sample),
    .nxt          (state_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= ltdc_pkg::PH_LEFT;
      state.tick_count    <= 16'd0;
      state.reading_left  <= 12'd0;
      state.reading_right <= 12'd0;
      state.reading_up    <= 12'd0;
      state.center_pan    <= ltdc_pkg::CENTER_RESET;
      state.center_tilt   <= ltdc_pkg::CENTER_RESET;
      state.pan_level     <= ltdc_pkg::CENTER_RESET;
      state.tilt_level    <= ltdc_pkg::CENTER_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (!result_valid || take) begin
        out_reg <= res_next;
      end else begin
        skid_reg <= res_next;
      end
    end
  end

  assign pan_drive       = out_reg.pan_drive;
  assign tilt_drive      = out_reg.tilt_drive;
  assign center_pan_out  = out_reg.center_pan;
  assign center_tilt_out = out_reg.center_tilt;
  assign probe_phase     = out_reg.probe_phase;
  assign cycle_done      = out_reg.cycle_done;

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && cycle_done |->
      probe_phase == ltdc_pkg::PH_HOLD || probe_phase == ltdc_pkg::PH_LEFT)
    else $error("correction flagged outside hold or left phase");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry full while output register empty");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

endmodule

/* sim/ltdc_checker.sv */
`timescale 1ns / 1ps

module ltdc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        sample_valid,
  input  logic        sample_stall,
  input  logic [11:0] light_sample,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [15:0] pan_drive,
  input  logic [15:0] tilt_drive,
  input  logic [15:0] center_pan_out,
  input  logic [15:0] center_tilt_out,
  input  logic [2:0]  probe_phase,
  input  logic        cycle_done,
  output int          mismatches,
  output int          in_flight,
  output int          ticks_checked,
  output int          corrections
);

  // tracker configuration as last written
  logic [15:0] lim_settle;
  logic [11:0] ofs;
  logic [11:0] dband;
  logic [11:0] step;
  logic [15:0] lim_hold;

  // tracker state
  ltdc_pkg::phase_t ph;
  logic [15:0] cnt;
  logic [11:0] rd_left, rd_right, rd_up, rd_down;
  logic [15:0] ctr_pan, ctr_tilt;
  logic [15:0] lvl_pan, lvl_tilt;

  ltdc_pkg::result_t expected_servo[$];

  function automatic logic [15:0] clamp_up(input logic [15:0] a, input logic [11:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 65535) ? 16'hFFFF : 16'(s);
  endfunction

  function automatic logic [15:0] clamp_down(input logic [15:0] a, input logic [11:0] b);
    return (int'(a) > int'(b)) ? 16'(int'(a) - int'(b)) : 16'd0;
  endfunction

  function automatic bit brighter(input logic [11:0] a, input logic [11:0] b,
                                  input logic [11:0] margin);
    return int'(a) > int'(b) + int'(margin);
  endfunction

  task automatic advance_tracker(input logic [11:0] s, output ltdc_pkg::result_t r);
    logic done;
    done = 1'b0;
    if (ph == ltdc_pkg::PH_HOLD) begin
      lvl_pan  = ctr_pan;
      lvl_tilt = ctr_tilt;
      cnt = cnt + 16'd1;
      if (cnt >= lim_hold) begin
        ph  = ltdc_pkg::PH_LEFT;
        cnt = '0;
      end
    end else begin
      case (ph)
        ltdc_pkg::PH_LEFT:  lvl_pan  = clamp_down(ctr_pan, ofs);
        ltdc_pkg::PH_RIGHT: lvl_pan  = clamp_up(ctr_pan, ofs);
        ltdc_pkg::PH_UP:    lvl_tilt = clamp_up(ctr_tilt, ofs);
        default:            lvl_tilt = clamp_down(ctr_tilt, ofs);
      endcase
      cnt = cnt + 16'd1;
      // a wrapped count latches too, and a settle of zero behaves as one
      if (cnt >= lim_settle || cnt == 16'd0) begin
        cnt = '0;
        case (ph)
          ltdc_pkg::PH_LEFT: begin
            rd_left = s;
            ph = ltdc_pkg::PH_RIGHT;
          end
          ltdc_pkg::PH_RIGHT: begin
            rd_right = s;
            ph = ltdc_pkg::PH_UP;
          end
          ltdc_pkg::PH_UP: begin
            rd_up = s;
            ph = ltdc_pkg::PH_DOWN;
          end
          default: begin
            rd_down = s;
            if (brighter(rd_left, rd_right, dband))
              ctr_pan = clamp_down(ctr_pan, step);
            else if (brighter(rd_right, rd_left, dband))
              ctr_pan = clamp_up(ctr_pan, step);
            if (brighter(rd_up, rd_down, dband))
              ctr_tilt = clamp_up(ctr_tilt, step);
            else if (brighter(rd_down, rd_up, dband))
              ctr_tilt = clamp_down(ctr_tilt, step);
            lvl_pan  = ctr_pan;
            lvl_tilt = ctr_tilt;
            done = 1'b1;
            ph = (lim_hold == 16'd0) ? ltdc_pkg::PH_LEFT : ltdc_pkg::PH_HOLD;
          end
        endcase
      end
    end
    r.pan_drive   = lvl_pan;
    r.tilt_drive  = lvl_tilt;
    r.center_pan  = ctr_pan;
    r.center_tilt = ctr_tilt;
    r.probe_phase = ph;
    r.cycle_done  = done;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    ltdc_pkg::result_t want;
    ltdc_pkg::result_t next_want;
    if (rst) begin
      lim_settle = ltdc_pkg::SETTLE_TICKS_RESET;
      ofs        = ltdc_pkg::PROBE_OFFSET_RESET;
      dband      = ltdc_pkg::DEADBAND_RESET;
      step       = ltdc_pkg::STEP_SIZE_RESET;
      lim_hold   = ltdc_pkg::HOLD_TICKS_RESET;
      ph         = ltdc_pkg::PH_LEFT;
      cnt        = '0;
      rd_left    = '0;
      rd_right   = '0;
      rd_up      = '0;
      rd_down    = '0;
      ctr_pan    = ltdc_pkg::CENTER_RESET;
      ctr_tilt   = ltdc_pkg::CENTER_RESET;
      lvl_pan    = ltdc_pkg::CENTER_RESET;
      lvl_tilt   = ltdc_pkg::CENTER_RESET;
      expected_servo.delete();
      mismatches    = 0;
      ticks_checked = 0;
      corrections   = 0;
      in_flight    <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ltdc_pkg::CFG_SETTLE_TICKS: lim_settle = cfg_data;
          ltdc_pkg::CFG_PROBE_OFFSET: ofs        = cfg_data[11:0];
          ltdc_pkg::CFG_DEADBAND:     dband      = cfg_data[11:0];
          ltdc_pkg::CFG_STEP_SIZE:    step       = cfg_data[11:0];
          ltdc_pkg::CFG_HOLD_TICKS:   lim_hold   = cfg_data;
          default: ;
        endcase
      end
      // pop before push: a result can never belong to an item taken this edge
      if (result_valid && !result_stall) begin
        if (expected_servo.size() == 0) begin
          $error("result item with no tick pending");
          mismatches++;
        end else begin
          want = expected_servo.pop_front();
          check_field("pan_drive", want.pan_drive, pan_drive);
          check_field("tilt_drive", want.tilt_drive, tilt_drive);
          check_field("center_pan_out", want.center_pan, center_pan_out);
          check_field("center_tilt_out", want.center_tilt, center_tilt_out);
          check_field("probe_phase", 16'(want.probe_phase), 16'(probe_phase));
          check_field("cycle_done", 16'(want.cycle_done), 16'(cycle_done));
          ticks_checked++;
          if (want.cycle_done) corrections++;
        end
      end
      if (sample_valid && !sample_stall) begin
        advance_tracker(light_sample, next_want);
        expected_servo.push_back(next_want);
      end
      in_flight <= expected_servo.size();
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = ltdc_pkg::CFG_SETTLE_TICKS;
  logic [15:0] cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic [11:0] light_sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [15:0] pan_drive, tilt_drive, center_pan_out, center_tilt_out;
  logic [2:0]  probe_phase;
  logic        cycle_done;

  int mismatch_count, in_flight, ticks_checked, corrections;
  int settings_written = 0;
  bit steady = 1'b0;
  int base_light = 2048;

  always #5 clk = ~clk;

  light_tracker_dither_control dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .light_sample,
    .result_valid, .result_stall,
    .pan_drive, .tilt_drive, .center_pan_out, .center_tilt_out,
    .probe_phase, .cycle_done
  );

  ltdc_checker u_checker (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .light_sample,
    .result_valid, .result_stall,
    .pan_drive, .tilt_drive, .center_pan_out, .center_tilt_out,
    .probe_phase, .cycle_done,
    .mismatches(mismatch_count), .in_flight, .ticks_checked, .corrections
  );

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side backpressure
  always @(posedge clk) begin
    result_stall <= !steady && ($urandom_range(99) < 29);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // 12-bit registers get junk in the upper bits, which must be dropped
  task automatic set_tracker(input logic [15:0] settle, input logic [11:0] offset,
                             input logic [11:0] margin, input logic [11:0] stride,
                             input logic [15:0] hold);
    write_reg(ltdc_pkg::CFG_SETTLE_TICKS, settle);
    write_reg(ltdc_pkg::CFG_PROBE_OFFSET, {4'($urandom), offset});
    write_reg(ltdc_pkg::CFG_DEADBAND, {4'($urandom), margin});
    write_reg(ltdc_pkg::CFG_STEP_SIZE, {4'($urandom), stride});
    write_reg(ltdc_pkg::CFG_HOLD_TICKS, hold);
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_write <= 1'b0;
    settings_written++;
  endtask

  task automatic send_tick(input logic [11:0] v);
    while (!steady && $urandom_range(99) < 29) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    light_sample <= v;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_light();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(1) ? 12'hFFF : 12'h000;
    if (r < 40) begin
      // near a common level, to land around the deadband
      v = base_light + $urandom_range(0, 40) - 20;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
    end
    return 12'($urandom);
  endfunction

  task automatic random_setting();
    logic [15:0] settle, hold;
    logic [11:0] offset, margin, stride;
    case ($urandom_range(9))
      0:       settle = 16'd0;
      1:       settle = 16'd1;
      default: settle = 16'($urandom_range(1, 5));
    endcase
    case ($urandom_range(3))
      0:       offset = 12'd0;
      1:       offset = 12'hFFF;
      default: offset = 12'($urandom);
    endcase
    case ($urandom_range(4))
      0:       margin = 12'd0;
      1:       margin = 12'hFFF;
      2, 3:    margin = 12'($urandom_range(0, 64));
      default: margin = 12'($urandom);
    endcase
    case ($urandom_range(3))
      0:       stride = 12'd0;
      1:       stride = 12'hFFF;
      default: stride = 12'($urandom);
    endcase
    case ($urandom_range(3))
      0:       hold = 16'd0;
      1:       hold = 16'd1;
      default: hold = 16'($urandom_range(0, 6));
    endcase
    set_tracker(settle, offset, margin, stride, hold);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first ticks of the left probe
    send_tick(12'hFFF);
    send_tick(12'h000);
    drain_results();

    // zero settle, widest offset and step: move centers both ways, pan down to zero
    set_tracker(16'd0, 12'hFFF, 12'd0, 12'hFFF, 16'd0);
    send_tick(12'hFFF); send_tick(12'h000); send_tick(12'hFFF); send_tick(12'h000);
    send_tick(12'h000); send_tick(12'hFFF); send_tick(12'h000); send_tick(12'hFFF);
    send_tick(12'd100); send_tick(12'd100); send_tick(12'd100); send_tick(12'd100);
    drain_results();

    // full-scale difference held back by the widest deadband, one hold tick
    set_tracker(16'd1, 12'd0, 12'hFFF, 12'hFFF, 16'd1);
    send_tick(12'hFFF); send_tick(12'h000); send_tick(12'h000); send_tick(12'hFFF);
    send_tick(12'd7);
    drain_results();

    // difference exactly at the deadband, then one above it
    set_tracker(16'd1, 12'd20, 12'd15, 12'd10, 16'd0);
    send_tick(12'd115); send_tick(12'd100); send_tick(12'd100); send_tick(12'd115);
    send_tick(12'd116); send_tick(12'd100); send_tick(12'd100); send_tick(12'd116);
    drain_results();

    // longest settle and hold, then lower each while a count is running
    set_tracker(16'hFFFF, 12'($urandom), 12'($urandom_range(0, 64)), 12'($urandom), 16'hFFFF);
    repeat (40) send_tick(pick_light());
    drain_results();
    set_tracker(16'd2, 12'($urandom), 12'($urandom_range(0, 64)), 12'($urandom), 16'hFFFF);
    repeat (20) send_tick(pick_light());
    drain_results();
    set_tracker(16'd2, 12'($urandom), 12'($urandom_range(0, 64)), 12'($urandom), 16'd3);
    repeat (10) send_tick(pick_light());
    drain_results();

    for (int p = 0; p < 10; p++) begin
      steady = (p == 3 || p == 4);
      base_light = $urandom_range(0, 4095);
      if (p == 0)
        set_tracker(ltdc_pkg::SETTLE_TICKS_RESET, ltdc_pkg::PROBE_OFFSET_RESET,
                    ltdc_pkg::DEADBAND_RESET, ltdc_pkg::STEP_SIZE_RESET,
                    ltdc_pkg::HOLD_TICKS_RESET);
      else if (p > 1)
        random_setting();
      repeat (130) send_tick(pick_light());
      drain_results();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    $display("checked %0d ticks with %0d center corrections over %0d register settings",
             ticks_checked, corrections, settings_written);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
